FILE: rtl/i2cm_pkg.sv
package i2cm_pkg;

    localparam int MSG_DEPTH = 16;
    localparam int PTR_W     = $clog2(MSG_DEPTH + 1);
    localparam int IDX_W     = $clog2(MSG_DEPTH);

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_BEGIN = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    localparam logic [1:0] ST_NONE      = 2'd0;
    localparam logic [1:0] ST_OK        = 2'd1;
    localparam logic [1:0] ST_ADDR_NACK = 2'd2;
    localparam logic [1:0] ST_DATA_NACK = 2'd3;

    localparam logic REG_LOW_TICKS  = 1'b0;
    localparam logic REG_HIGH_TICKS = 1'b1;

    localparam logic [7:0] LOW_TICKS_RST  = 8'd2;
    localparam logic [7:0] HIGH_TICKS_RST = 8'd1;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
        logic [4:0] byte_count;
        logic       scl_in;
        logic       sda_in;
    } t_in;

    typedef struct packed {
        logic       scl_pull_low;
        logic       sda_pull_low;
        logic       busy_res;
        logic [7:0] read_data;
        logic       read_valid;
        logic       done_res;
        logic [1:0] status;
    } t_out;

    typedef struct packed {
        logic [7:0] low_ticks;
        logic [7:0] high_ticks;
    } t_cfg;

endpackage

FILE: rtl/i2cm_regs.sv
module i2cm_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output i2cm_pkg::t_cfg o_cfg
);
    import i2cm_pkg::*;

    logic [7:0] r_low_ticks;
    logic [7:0] r_high_ticks;
    logic       wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_ticks  <= LOW_TICKS_RST;
            r_high_ticks <= HIGH_TICKS_RST;
        end else if (wr_en) begin
            if (paddr[2] == REG_LOW_TICKS) begin
                r_low_ticks <= pwdata[7:0];
            end else begin
                r_high_ticks <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_LOW_TICKS) begin
            prdata = {24'd0, r_low_ticks};
        end else begin
            prdata = {24'd0, r_high_ticks};
        end
    end

    assign o_cfg.low_ticks  = r_low_ticks;
    assign o_cfg.high_ticks = r_high_ticks;

endmodule

FILE: rtl/i2cm_core.sv
module i2cm_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  i2cm_pkg::t_in  i_item,
    input  i2cm_pkg::t_cfg i_cfg,
    output i2cm_pkg::t_out o_res
);
    import i2cm_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START_WAIT,
        PH_START_HOLD,
        PH_LOW,
        PH_HIGH,
        PH_STOP_HIGH,
        PH_STOP_FREE
    } t_phase;

    logic [7:0]       r_store [MSG_DEPTH];
    logic             r_addr_lsb;
    logic [PTR_W-1:0] r_load_ptr,  n_load_ptr;
    t_phase           r_phase,     n_phase;
    logic [3:0]       r_bit_cnt,   n_bit_cnt;
    logic [7:0]       r_shift,     n_shift;
    logic [PTR_W-1:0] r_byte_pos,  n_byte_pos;
    logic [PTR_W-1:0] r_bytes_left, n_bytes_left;
    logic [7:0]       r_wait,      n_wait;
    logic             r_read_mode, n_read_mode;
    logic             r_addr_phase, n_addr_phase;
    logic             r_scl,       n_scl;
    logic             r_sda,       n_sda;
    logic [1:0]       r_status,    n_status;

    logic             store_we;
    logic [7:0]       store_rd;
    logic [7:0]       low_eff, high_eff;
    logic [8:0]       wc_inc;
    logic             low_hit, high_hit;
    logic             wr_now, wr_next;
    logic             do_setup, do_enter;
    logic [7:0]       sh;
    logic [3:0]       bc;
    logic [PTR_W-1:0] cnt, bl;
    logic [7:0]       rdata;
    logic             rvalid, done;

    // a tick register of zero behaves as one
    assign low_eff  = (i_cfg.low_ticks  == 8'd0) ? 8'd1 : i_cfg.low_ticks;
    assign high_eff = (i_cfg.high_ticks == 8'd0) ? 8'd1 : i_cfg.high_ticks;
    assign wc_inc   = {1'b0, r_wait} + 9'd1;
    assign low_hit  = wc_inc >= {1'b0, low_eff};
    assign high_hit = wc_inc >= {1'b0, high_eff};
    assign wr_now   = r_addr_phase || !r_read_mode;
    assign store_rd = (r_byte_pos < PTR_W'(MSG_DEPTH)) ? r_store[r_byte_pos[IDX_W-1:0]] : 8'd0;

    always_comb begin
        n_load_ptr   = r_load_ptr;
        n_phase      = r_phase;
        n_bit_cnt    = r_bit_cnt;
        n_shift      = r_shift;
        n_byte_pos   = r_byte_pos;
        n_bytes_left = r_bytes_left;
        n_wait       = r_wait;
        n_read_mode  = r_read_mode;
        n_addr_phase = r_addr_phase;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_status     = r_status;
        store_we     = 1'b0;
        do_setup     = 1'b0;
        do_enter     = 1'b0;
        rdata        = 8'd0;
        rvalid       = 1'b0;
        done         = 1'b0;
        sh           = r_shift;
        bc           = r_bit_cnt;
        cnt          = '0;
        bl           = r_bytes_left;
        wr_next      = 1'b0;

        case (i_item.func)
            FUNC_LOAD: begin
                if (r_phase == PH_IDLE && r_load_ptr < PTR_W'(MSG_DEPTH)) begin
                    store_we   = 1'b1;
                    n_load_ptr = r_load_ptr + PTR_W'(1);
                end
            end
            FUNC_BEGIN: begin
                if (r_phase == PH_IDLE) begin
                    if (i_item.byte_count == 5'd0) begin
                        cnt = PTR_W'(1);
                    end else if (int'(i_item.byte_count) > MSG_DEPTH) begin
                        cnt = PTR_W'(MSG_DEPTH);
                    end else begin
                        cnt = PTR_W'(i_item.byte_count);
                    end
                    n_bytes_left = cnt;
                    n_byte_pos   = '0;
                    n_load_ptr   = '0;
                    n_addr_phase = 1'b1;
                    n_read_mode  = r_addr_lsb;
                    n_status     = ST_NONE;
                    n_shift      = 8'hFF;
                    n_bit_cnt    = 4'd0;
                    n_scl        = 1'b0;
                    n_sda        = 1'b0;
                    n_wait       = 8'd0;
                    n_phase      = PH_START_WAIT;
                end
            end
            FUNC_TICK: begin
                case (r_phase)
                    PH_START_WAIT: begin
                        if (!i_item.scl_in) begin
                            n_wait = 8'd0;
                        end else if (high_hit) begin
                            n_sda   = 1'b1;
                            n_wait  = 8'd0;
                            n_phase = PH_START_HOLD;
                        end else begin
                            n_wait = wc_inc[7:0];
                        end
                    end
                    PH_START_HOLD: begin
                        n_wait = wc_inc[7:0];
                        if (high_hit) begin
                            n_scl    = 1'b1;
                            n_sda    = 1'b0;
                            do_setup = 1'b1;
                        end
                    end
                    PH_LOW: begin
                        n_wait = wc_inc[7:0];
                        if (low_hit) begin
                            n_scl   = 1'b0;
                            n_wait  = 8'd0;
                            n_phase = PH_HIGH;
                        end
                    end
                    PH_HIGH: begin
                        if (!i_item.scl_in) begin
                            n_wait = 8'd0;
                        end else begin
                            // sample SDA on the first tick SCL is seen high
                            if (r_wait == 8'd0) begin
                                sh = {r_shift[6:0], i_item.sda_in};
                            end
                            n_shift = sh;
                            n_wait  = wc_inc[7:0];
                            if (high_hit) begin
                                n_scl = 1'b1;
                                if (r_bit_cnt < 4'd8) begin
                                    bc        = r_bit_cnt + 4'd1;
                                    n_bit_cnt = bc;
                                    if (bc == 4'd8) begin
                                        if (wr_now) begin
                                            n_shift = 8'hFF;
                                        end else begin
                                            rdata   = sh;
                                            rvalid  = 1'b1;
                                            // ACK unless this is the last byte
                                            n_shift = (r_bytes_left == PTR_W'(1)) ? 8'hFF : 8'h00;
                                        end
                                    end
                                    do_enter = 1'b1;
                                end else if (wr_now && sh[0]) begin
                                    n_sda    = 1'b0;
                                    n_shift  = 8'hFF;
                                    n_phase  = PH_IDLE;
                                    n_status = r_addr_phase ? ST_ADDR_NACK : ST_DATA_NACK;
                                    done     = 1'b1;
                                end else begin
                                    if (wr_now) begin
                                        n_addr_phase = 1'b0;
                                    end
                                    n_shift = 8'hFF;
                                    if (r_bytes_left != '0) begin
                                        bl = r_bytes_left - PTR_W'(1);
                                    end
                                    n_bytes_left = bl;
                                    if (bl == '0) begin
                                        n_phase = PH_STOP_HIGH;
                                        n_scl   = 1'b0;
                                        n_sda   = 1'b1;
                                        n_wait  = 8'd0;
                                    end else begin
                                        do_setup = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                    PH_STOP_HIGH: begin
                        if (!i_item.scl_in) begin
                            n_wait = 8'd0;
                        end else if (high_hit) begin
                            n_sda   = 1'b0;
                            n_wait  = 8'd0;
                            n_phase = PH_STOP_FREE;
                        end else begin
                            n_wait = wc_inc[7:0];
                        end
                    end
                    PH_STOP_FREE: begin
                        n_wait = wc_inc[7:0];
                        if (low_hit) begin
                            n_phase  = PH_IDLE;
                            n_status = ST_OK;
                            done     = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        wr_next = n_addr_phase || !n_read_mode;

        // load the next byte when writing, then drop SCL for its first bit
        if (do_setup) begin
            if (wr_next) begin
                n_shift    = store_rd;
                n_byte_pos = r_byte_pos + PTR_W'(1);
            end else begin
                n_shift = 8'hFF;
            end
            n_bit_cnt = 4'd0;
            do_enter  = 1'b1;
        end

        if (do_enter) begin
            n_scl   = 1'b1;
            n_wait  = 8'd0;
            n_phase = PH_LOW;
            if (n_bit_cnt < 4'd8) begin
                n_sda = wr_next ? ~n_shift[7] : 1'b0;
            end else begin
                n_sda = wr_next ? 1'b0 : ~n_shift[7];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_ptr   <= '0;
            r_phase      <= PH_IDLE;
            r_bit_cnt    <= 4'd0;
            r_shift      <= 8'hFF;
            r_byte_pos   <= '0;
            r_bytes_left <= '0;
            r_wait       <= 8'd0;
            r_read_mode  <= 1'b0;
            r_addr_phase <= 1'b0;
            r_scl        <= 1'b0;
            r_sda        <= 1'b0;
            r_status     <= ST_NONE;
        end else if (i_step) begin
            r_load_ptr   <= n_load_ptr;
            r_phase      <= n_phase;
            r_bit_cnt    <= n_bit_cnt;
            r_shift      <= n_shift;
            r_byte_pos   <= n_byte_pos;
            r_bytes_left <= n_bytes_left;
            r_wait       <= n_wait;
            r_read_mode  <= n_read_mode;
            r_addr_phase <= n_addr_phase;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_status     <= n_status;
        end
    end

    // store has no reset; address LSB is mirrored when entry 0 is written
    always_ff @(posedge i_clk) begin
        if (i_step && store_we) begin
            r_store[r_load_ptr[IDX_W-1:0]] <= i_item.data_byte;
            if (r_load_ptr == '0) begin
                r_addr_lsb <= i_item.data_byte[0];
            end
        end
    end

    assign o_res.scl_pull_low = n_scl;
    assign o_res.sda_pull_low = n_sda;
    assign o_res.busy_res     = (n_phase != PH_IDLE);
    assign o_res.read_data    = rdata;
    assign o_res.read_valid   = rvalid;
    assign o_res.done_res     = done;
    assign o_res.status       = n_status;

endmodule

FILE: rtl/i2c_master_transaction_top.sv
// I2C master transaction engine. Load beats fill a 16-byte message store (address
// byte first, LSB set means read); a begin beat starts START, address, data and
// STOP on the bus, and each tick beat carries sampled SCL/SDA and advances the
// bus sequencer by one step. Every input beat yields exactly one result beat
// with the open-drain drives, busy, read byte and status. One beat is taken
// per clock while the output side keeps up; a beat passes an input register
// and the sequencer logic into the result register, and waits in the input
// register while the output side is not ready. Timing registers (APB, byte 0
// low ticks, byte 4 high ticks) may be written only while no transfer is running.
module i2c_master_transaction_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  i2cm_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output i2cm_pkg::t_out o_out_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import i2cm_pkg::*;

    logic   r_in_valid;
    t_in    r_in;
    logic   r_out_valid;
    t_out   r_out;
    logic   step;
    t_cfg   cfg;
    t_out   res;

    // the held beat moves on when the result register is empty or being taken
    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    i2cm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    i2cm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (step) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.done_res |-> !o_out_data.busy_res)
        else $error("transfer end reported while still busy");

    a_done_has_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.done_res |-> o_out_data.status != ST_NONE)
        else $error("transfer end without an outcome");

    a_read_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.read_valid |-> !o_out_data.done_res
            && o_out_data.busy_res)
        else $error("read byte outside a running transfer");

    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

endmodule
